### sv/ffha_pkg.sv
// Shared constants, codes and word types for the first-fit heap allocator.
package ffha_pkg;

  localparam int HEAP_BYTES   = 512;
  localparam int HEADER_BYTES = 8;
  localparam int OFF_W        = $clog2(HEAP_BYTES);
  localparam int REQ_W        = 10;
  localparam int SIZE_W       = 17;
  localparam int SUM_W        = SIZE_W + 1;

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  localparam logic [1:0] ST_ALLOC = 2'd0;
  localparam logic [1:0] ST_OOM   = 2'd1;
  localparam logic [1:0] ST_FREED = 2'd2;

  typedef struct packed {
    logic             mode;
    logic [REQ_W-1:0] request_size;
    logic [OFF_W-1:0] release_offset;
  } ffha_in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [OFF_W-1:0] payload_offset;
  } ffha_out_t;

  typedef struct packed {
    logic idle;
    logic res_valid;
  } ffha_stat_t;

endpackage

### sv/first_fit_heap_allocator_unit.sv
// Top level of the first-fit heap allocator: handshake and result register.
//
//   channel  dir  word                   handshake
//   in_      in   ffha_pkg::ffha_in_t    in_valid / in_stall
//   out_     out  ffha_pkg::ffha_out_t   out_valid / out_stall
//
// Allocate: one header RAM read per header visited on the walk, plus up to 3
// header writes and a result state.
// Free: reads the block, its next and its previous header, merging with each free one.
// After reset the header RAM is swept, all 512 entries, one entry a cycle; in_stall is high.
// Results wait in an output register; a new word is taken while one waits there.
module first_fit_heap_allocator_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  ffha_pkg::ffha_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output ffha_pkg::ffha_out_t out_data
);

  ffha_pkg::ffha_stat_t stat;
  ffha_pkg::ffha_out_t  res_word;
  logic                 res_ready;
  logic                 out_valid_r, out_valid_nxt;
  ffha_pkg::ffha_out_t  out_data_r;

  assign in_stall  = !stat.idle;
  assign res_ready = !out_valid_r || !out_stall;

  ffha_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid && stat.idle),
    .req_word  (in_data),
    .res_ready (res_ready),
    .stat      (stat),
    .res_word  (res_word)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (stat.res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.res_valid && res_ready) begin
      out_data_r <= res_word;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### sv/ffha_engine.sv
// Header store and walk/merge sequencer of the heap allocator.
module ffha_engine (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               req_valid,
  input  ffha_pkg::ffha_in_t req_word,
  input  logic               res_ready,
  output ffha_pkg::ffha_stat_t stat,
  output ffha_pkg::ffha_out_t  res_word
);

  localparam int OFF_W  = ffha_pkg::OFF_W;
  localparam int REQ_W  = ffha_pkg::REQ_W;
  localparam int SIZE_W = ffha_pkg::SIZE_W;
  localparam int SUM_W  = ffha_pkg::SUM_W;
  localparam int DEPTH  = ffha_pkg::HEAP_BYTES;
  localparam logic [SUM_W-1:0]  HDR_S  = SUM_W'(ffha_pkg::HEADER_BYTES);
  localparam logic [SUM_W-1:0]  HEAP_S = SUM_W'(ffha_pkg::HEAP_BYTES);
  localparam logic [OFF_W-1:0]  HDR_O  = OFF_W'(ffha_pkg::HEADER_BYTES);
  localparam logic [SIZE_W-1:0] INIT_SIZE =
    SIZE_W'(ffha_pkg::HEAP_BYTES - ffha_pkg::HEADER_BYTES);

  typedef enum logic [15:0] {
    S_CLEAR   = 16'h0001,
    S_IDLE    = 16'h0002,
    S_A_RD    = 16'h0004,
    S_A_EV    = 16'h0008,
    S_A_SPLIT = 16'h0010,
    S_A_TAIL  = 16'h0020,
    S_F_RD    = 16'h0040,
    S_F_EV    = 16'h0080,
    S_F_NRD   = 16'h0100,
    S_F_NEV   = 16'h0200,
    S_F_NTAIL = 16'h0400,
    S_F_BACK  = 16'h0800,
    S_F_PRD   = 16'h1000,
    S_F_PEV   = 16'h2000,
    S_F_PTAIL = 16'h4000,
    S_DONE    = 16'h8000
  } state_t;

  state_t              state_r, state_nxt;
  logic [OFF_W-1:0]    clr_r, clr_nxt;
  logic [OFF_W-1:0]    addr_r, addr_nxt;
  logic [OFF_W-1:0]    cur_r, cur_nxt;
  logic [REQ_W-1:0]    req_r, req_nxt;
  logic [SIZE_W-1:0]   size_r, size_nxt;
  logic [SIZE_W-1:0]   prior_r, prior_nxt;
  logic [SIZE_W-1:0]   aux_r, aux_nxt;
  ffha_pkg::ffha_out_t res_r, res_nxt;

  logic                free_mem  [DEPTH];
  logic [SIZE_W-1:0]   prior_mem [DEPTH];
  logic [SIZE_W-1:0]   size_mem  [DEPTH];
  logic                rd_free_r;
  logic [SIZE_W-1:0]   rd_prior_r;
  logic [SIZE_W-1:0]   rd_size_r;

  logic [OFF_W-1:0]    wr_addr;
  logic                we_free, we_prior, we_size;
  logic                wd_free;
  logic [SIZE_W-1:0]   wd_prior, wd_size;

  logic [SUM_W-1:0]    cur_ext, req_ext, rd_size_ext;
  logic [SUM_W-1:0]    walk_sum, need, split_sum, tail_sum, merge_sum, back, prev_sum;
  logic [SIZE_W-1:0]   rest;

  always_ff @(posedge clk) begin
    if (we_free) begin
      free_mem[wr_addr] <= wd_free;
    end
    if (we_prior) begin
      prior_mem[wr_addr] <= wd_prior;
    end
    if (we_size) begin
      size_mem[wr_addr] <= wd_size;
    end
    rd_free_r  <= free_mem[addr_r];
    rd_prior_r <= prior_mem[addr_r];
    rd_size_r  <= size_mem[addr_r];
  end

  assign cur_ext     = SUM_W'(cur_r);
  assign req_ext     = SUM_W'(req_r);
  assign rd_size_ext = SUM_W'(rd_size_r);
  assign walk_sum    = cur_ext + rd_size_ext + HDR_S;
  assign need        = req_ext + HDR_S;
  assign split_sum   = cur_ext + need;
  assign tail_sum    = cur_ext + SUM_W'(size_r) + HDR_S;
  assign merge_sum   = SUM_W'(size_r) + HDR_S + rd_size_ext;
  assign back        = SUM_W'(prior_r) + HDR_S;
  assign prev_sum    = cur_ext - back;
  assign rest        = size_r - need[SIZE_W-1:0];

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    addr_nxt  = addr_r;
    cur_nxt   = cur_r;
    req_nxt   = req_r;
    size_nxt  = size_r;
    prior_nxt = prior_r;
    aux_nxt   = aux_r;
    res_nxt   = res_r;
    wr_addr   = cur_r;
    we_free   = 1'b0;
    we_prior  = 1'b0;
    we_size   = 1'b0;
    wd_free   = 1'b0;
    wd_prior  = '0;
    wd_size   = '0;
    case (state_r)
      S_CLEAR: begin
        wr_addr  = clr_r;
        we_free  = 1'b1;
        we_prior = 1'b1;
        we_size  = 1'b1;
        wd_free  = (clr_r == '0);
        wd_size  = (clr_r == '0) ? INIT_SIZE : '0;
        clr_nxt  = clr_r + 1'b1;
        if (clr_r == '1) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          req_nxt = req_word.request_size;
          if (req_word.mode == ffha_pkg::MODE_ALLOC) begin
            cur_nxt   = '0;
            addr_nxt  = '0;
            state_nxt = S_A_RD;
          end else if (req_word.release_offset < HDR_O) begin
            res_nxt   = '{status: ffha_pkg::ST_FREED, payload_offset: '0};
            state_nxt = S_DONE;
          end else begin
            cur_nxt   = req_word.release_offset - HDR_O;
            addr_nxt  = req_word.release_offset - HDR_O;
            state_nxt = S_F_RD;
          end
        end
      end
      S_A_RD: begin
        state_nxt = S_A_EV;
      end
      S_A_EV: begin
        if (rd_free_r && rd_size_r == SIZE_W'(req_r)) begin
          we_free   = 1'b1;
          res_nxt   = '{status: ffha_pkg::ST_ALLOC, payload_offset: cur_r + HDR_O};
          state_nxt = S_DONE;
        end else if (rd_free_r && rd_size_ext >= need) begin
          we_free   = 1'b1;
          we_size   = 1'b1;
          wd_size   = SIZE_W'(req_r);
          size_nxt  = rd_size_r;
          res_nxt   = '{status: ffha_pkg::ST_ALLOC, payload_offset: cur_r + HDR_O};
          state_nxt = S_A_SPLIT;
        end else if (walk_sum >= HEAP_S) begin
          res_nxt   = '{status: ffha_pkg::ST_OOM, payload_offset: '0};
          state_nxt = S_DONE;
        end else begin
          cur_nxt   = walk_sum[OFF_W-1:0];
          addr_nxt  = walk_sum[OFF_W-1:0];
          state_nxt = S_A_RD;
        end
      end
      S_A_SPLIT: begin
        aux_nxt = rest;
        if (split_sum < HEAP_S) begin
          wr_addr  = split_sum[OFF_W-1:0];
          we_free  = 1'b1;
          we_prior = 1'b1;
          we_size  = 1'b1;
          wd_free  = 1'b1;
          wd_prior = SIZE_W'(req_r);
          wd_size  = rest;
        end
        state_nxt = S_A_TAIL;
      end
      S_A_TAIL: begin
        if (tail_sum < HEAP_S) begin
          wr_addr  = tail_sum[OFF_W-1:0];
          we_prior = 1'b1;
          wd_prior = aux_r;
        end
        state_nxt = S_DONE;
      end
      S_F_RD: begin
        state_nxt = S_F_EV;
      end
      S_F_EV: begin
        we_free   = 1'b1;
        wd_free   = 1'b1;
        size_nxt  = rd_size_r;
        prior_nxt = rd_prior_r;
        res_nxt   = '{status: ffha_pkg::ST_FREED, payload_offset: '0};
        if (walk_sum < HEAP_S) begin
          addr_nxt  = walk_sum[OFF_W-1:0];
          state_nxt = S_F_NRD;
        end else begin
          state_nxt = S_F_BACK;
        end
      end
      S_F_NRD: begin
        state_nxt = S_F_NEV;
      end
      S_F_NEV: begin
        if (rd_free_r) begin
          we_size   = 1'b1;
          wd_size   = merge_sum[SIZE_W-1:0];
          size_nxt  = merge_sum[SIZE_W-1:0];
          state_nxt = S_F_NTAIL;
        end else begin
          state_nxt = S_F_BACK;
        end
      end
      S_F_NTAIL: begin
        if (tail_sum < HEAP_S) begin
          wr_addr  = tail_sum[OFF_W-1:0];
          we_prior = 1'b1;
          wd_prior = size_r;
        end
        state_nxt = S_F_BACK;
      end
      S_F_BACK: begin
        if (cur_r != '0 && cur_ext >= back) begin
          addr_nxt  = prev_sum[OFF_W-1:0];
          state_nxt = S_F_PRD;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_F_PRD: begin
        state_nxt = S_F_PEV;
      end
      S_F_PEV: begin
        if (rd_free_r) begin
          wr_addr   = addr_r;
          we_size   = 1'b1;
          wd_size   = merge_sum[SIZE_W-1:0];
          aux_nxt   = merge_sum[SIZE_W-1:0];
          state_nxt = S_F_PTAIL;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_F_PTAIL: begin
        if (tail_sum < HEAP_S) begin
          wr_addr  = tail_sum[OFF_W-1:0];
          we_prior = 1'b1;
          wd_prior = aux_r;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r  <= addr_nxt;
    cur_r   <= cur_nxt;
    req_r   <= req_nxt;
    size_r  <= size_nxt;
    prior_r <= prior_nxt;
    aux_r   <= aux_nxt;
    res_r   <= res_nxt;
  end

  assign stat.idle      = (state_r == S_IDLE);
  assign stat.res_valid = (state_r == S_DONE);
  assign res_word       = res_r;

endmodule

### sv/ffha_chk.sv
// Port checker for the heap allocator, bound to the top level.
module ffha_chk (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input ffha_pkg::ffha_in_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input ffha_pkg::ffha_out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again without a busy cycle");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status == ffha_pkg::ST_ALLOC ||
                   out_data.status == ffha_pkg::ST_OOM ||
                   out_data.status == ffha_pkg::ST_FREED))
    else $error("bad status code");

  a_zero_offset: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ffha_pkg::ST_ALLOC |-> out_data.payload_offset == '0)
    else $error("offset set on a word that grants nothing");

  a_free_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.mode == ffha_pkg::MODE_FREE |=> !out_valid || in_stall)
    else $error("free finished with no result in flight");

endmodule

bind first_fit_heap_allocator_unit ffha_chk u_ffha_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
